// ===== design/light_sensor_lux_calculator_macros.svh =====
// Assertion macros for the lux calculator checker.
// Both expect signals named clk and arst_n in the using scope.
`ifndef LIGHT_SENSOR_LUX_CALCULATOR_MACROS_SVH
`define LIGHT_SENSOR_LUX_CALCULATOR_MACROS_SVH

// same-cycle implication
`define LSC_CHECK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lux calculator check failed");

// next-cycle implication
`define LSC_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lux calculator check failed");

`endif

// ===== design/lsc_pkg.sv =====
package lsc_pkg;

	localparam int COUNT_W = 16;
	localparam int LUX_W   = 18;
	localparam int PROD_W  = 32;
	localparam int SCALE_W = 19;
	localparam int BASE_W  = 15;
	localparam int CH_W    = 22;
	localparam int COEF_W  = 10;
	localparam int SEG_N   = 8;
	localparam int SEG_W   = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int CHAN_SHIFT  = 10;
	localparam int RATIO_SHIFT = 9;
	localparam int LUX_SHIFT   = 14;
	localparam int GAIN_SHIFT  = 4;

	// quotient bits resolved per divider stage
	localparam int DIV_STEP = 2;

	localparam logic [BASE_W-1:0] SCALE_SHORT   = 15'h7517;
	localparam logic [BASE_W-1:0] SCALE_MEDIUM  = 15'h0FE7;
	localparam logic [BASE_W-1:0] SCALE_NOMINAL = 15'h0400;

	typedef enum logic [1:0] {
		REG_INTEG_SEL  = 2'd0,
		REG_UNITY_GAIN = 2'd1,
		REG_CHIP_PKG   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		INTEG_SHORT  = 2'd0,
		INTEG_MEDIUM = 2'd1,
		INTEG_LONG   = 2'd2
	} integ_sel_t;

	// [package][segment]: 0 = T/FN/CL, 1 = CS
	localparam logic [COEF_W-1:0] LIM_TAB [2][SEG_N] = '{
		'{10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A, 10'h29A},
		'{10'h043, 10'h085, 10'h0C8, 10'h10A, 10'h14D, 10'h19A, 10'h29A, 10'h29A}
	};
	localparam logic [COEF_W-1:0] OFF_TAB [2][SEG_N] = '{
		'{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000},
		'{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
	};
	localparam logic [COEF_W-1:0] SLOPE_TAB [2][SEG_N] = '{
		'{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000},
		'{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B, 10'h000}
	};

endpackage

// ===== design/lsc_div.sv =====
// Pipelined restoring divider, DivStep quotient bits per stage.
// Divisor and a side payload ride along with each request.
module lsc_div #(
	parameter int DivStep = lsc_pkg::DIV_STEP
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [lsc_pkg::PROD_W-1:0] dividend,
	input  logic [lsc_pkg::CH_W-1:0]   divisor,
	input  logic [lsc_pkg::CH_W-1:0]   side,
	output logic                      out_valid,
	output logic [lsc_pkg::PROD_W-1:0] quotient,
	output logic [lsc_pkg::CH_W-1:0]   divisor_out,
	output logic [lsc_pkg::CH_W-1:0]   side_out
);

	localparam int NumStages = lsc_pkg::PROD_W / DivStep;

	logic                      valid_sn [NumStages];
	logic [lsc_pkg::CH_W-1:0]   rem_sn   [NumStages];
	logic [lsc_pkg::PROD_W-1:0] num_sn   [NumStages];
	logic [lsc_pkg::CH_W-1:0]   den_sn   [NumStages];
	logic [lsc_pkg::CH_W-1:0]   side_sn  [NumStages];

	for (genvar k = 0; k < NumStages; k++) begin : g_stage
		logic                      v_in;
		logic [lsc_pkg::CH_W-1:0]   rem_in;
		logic [lsc_pkg::PROD_W-1:0] num_in;
		logic [lsc_pkg::CH_W-1:0]   den_in;
		logic [lsc_pkg::CH_W-1:0]   side_in;
		logic [lsc_pkg::CH_W-1:0]   rem_nx;
		logic [lsc_pkg::PROD_W-1:0] num_nx;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign num_in  = dividend;
			assign den_in  = divisor;
			assign side_in = side;
		end else begin : g_next
			assign v_in    = valid_sn[k-1];
			assign rem_in  = rem_sn[k-1];
			assign num_in  = num_sn[k-1];
			assign den_in  = den_sn[k-1];
			assign side_in = side_sn[k-1];
		end

		// numerator shifts out at the top, quotient bits shift in at the bottom
		always_comb begin
			logic [lsc_pkg::CH_W:0]     trial;
			logic [lsc_pkg::CH_W-1:0]   rem_v;
			logic [lsc_pkg::PROD_W-1:0] num_v;
			rem_v = rem_in;
			num_v = num_in;
			for (int j = 0; j < DivStep; j++) begin
				trial = {rem_v, num_v[lsc_pkg::PROD_W-1]};
				if (trial >= {1'b0, den_in}) begin
					rem_v = lsc_pkg::CH_W'(trial - {1'b0, den_in});
					num_v = {num_v[lsc_pkg::PROD_W-2:0], 1'b1};
				end else begin
					rem_v = trial[lsc_pkg::CH_W-1:0];
					num_v = {num_v[lsc_pkg::PROD_W-2:0], 1'b0};
				end
			end
			rem_nx = rem_v;
			num_nx = num_v;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k] <= 1'b0;
			end else if (en) begin
				valid_sn[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[k]  <= rem_nx;
				num_sn[k]  <= num_nx;
				den_sn[k]  <= den_in;
				side_sn[k] <= side_in;
			end
		end
	end

	assign out_valid   = valid_sn[NumStages-1];
	assign quotient    = num_sn[NumStages-1];
	assign divisor_out = den_sn[NumStages-1];
	assign side_out    = side_sn[NumStages-1];

endmodule

// ===== design/light_sensor_lux_calculator.sv =====
// Integer lux from a broadband/infrared count pair. Fully pipelined: one
// request is taken every cycle while in_stall is low, and one lux result
// leaves per request, in order. The depth is set by the ratio divider,
// which resolves DivStep quotient bits in each stage. Stages: scale
// multiply, divider stages, ratio round and segment pick, coefficient
// multiply, clamp/round/shift, then the output register. A one-entry
// skid buffer behind the pipeline lets a new request in while a finished
// result waits; in_stall rises only when that buffer is full.
// Config registers (APB, 32-bit, byte address 4*i): 0x0 integration
// select, 0x4 unity gain, 0x8 chip-scale package. Write them only while
// the pipeline is empty.
module light_sensor_lux_calculator #(
	parameter int DivStep = lsc_pkg::DIV_STEP
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsc_pkg::ADDR_W-1:0]  paddr,
	input  logic [lsc_pkg::DATA_W-1:0]  pwdata,
	output logic [lsc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lsc_pkg::COUNT_W-1:0] broadband_count,
	input  logic [lsc_pkg::COUNT_W-1:0] infrared_count,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lsc_pkg::LUX_W-1:0]   lux
);

	localparam int MulW = lsc_pkg::COUNT_W + lsc_pkg::SCALE_W;

	// ---------------- config registers ----------------
	logic [1:0] integration_select_q;
	logic       unity_gain_q;
	logic       chip_scale_package_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integration_select_q <= lsc_pkg::INTEG_LONG;
			unity_gain_q         <= 1'b0;
			chip_scale_package_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lsc_pkg::REG_INTEG_SEL:  integration_select_q <= pwdata[1:0];
				lsc_pkg::REG_UNITY_GAIN: unity_gain_q         <= pwdata[0];
				lsc_pkg::REG_CHIP_PKG:   chip_scale_package_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lsc_pkg::REG_INTEG_SEL:  prdata = {30'd0, integration_select_q};
			lsc_pkg::REG_UNITY_GAIN: prdata = {31'd0, unity_gain_q};
			lsc_pkg::REG_CHIP_PKG:   prdata = {31'd0, chip_scale_package_q};
			default:                 prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// The whole pipeline advances unless the skid entry is occupied.
	logic skid_valid_q;
	logic en;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// ---------------- stage 1: scale both channels ----------------
	logic [lsc_pkg::BASE_W-1:0]  scale_base;
	logic [lsc_pkg::SCALE_W-1:0] scale;
	logic [MulW-1:0]             prod0;
	logic [MulW-1:0]             prod1;

	always_comb begin
		case (integration_select_q)
			lsc_pkg::INTEG_SHORT:  scale_base = lsc_pkg::SCALE_SHORT;
			lsc_pkg::INTEG_MEDIUM: scale_base = lsc_pkg::SCALE_MEDIUM;
			default:               scale_base = lsc_pkg::SCALE_NOMINAL;
		endcase
	end

	// 1x gain: scale times 16
	assign scale = unity_gain_q ? {scale_base, 4'd0} : {4'd0, scale_base};
	assign prod0 = MulW'(broadband_count) * MulW'(scale);
	assign prod1 = MulW'(infrared_count) * MulW'(scale);

	logic                       valid_s1;
	logic [lsc_pkg::PROD_W-1:0] p0_s1;
	logic [lsc_pkg::PROD_W-1:0] p1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// products wrap to 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= prod0[lsc_pkg::PROD_W-1:0];
			p1_s1 <= prod1[lsc_pkg::PROD_W-1:0];
		end
	end

	// ---------------- ratio divider ----------------
	// ch = product >> 10; numerator = ch1 << 10, exact in 32 bits.
	logic [lsc_pkg::CH_W-1:0]   ch0_w;
	logic [lsc_pkg::CH_W-1:0]   ch1_w;
	logic [lsc_pkg::PROD_W-1:0] numer_w;
	logic                       valid_dv;
	logic [lsc_pkg::PROD_W-1:0] quot_dv;
	logic [lsc_pkg::CH_W-1:0]   ch0_dv;
	logic [lsc_pkg::CH_W-1:0]   ch1_dv;

	assign ch0_w   = p0_s1[lsc_pkg::PROD_W-1:lsc_pkg::CHAN_SHIFT];
	assign ch1_w   = p1_s1[lsc_pkg::PROD_W-1:lsc_pkg::CHAN_SHIFT];
	assign numer_w = {ch1_w, (lsc_pkg::RATIO_SHIFT + 1)'(0)};

	lsc_div #(
		.DivStep (DivStep)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (valid_s1),
		.dividend    (numer_w),
		.divisor     (ch0_w),
		.side        (ch1_w),
		.out_valid   (valid_dv),
		.quotient    (quot_dv),
		.divisor_out (ch0_dv),
		.side_out    (ch1_dv)
	);

	// ---------------- stage 3: round ratio, pick segment ----------------
	// A zero scaled broadband channel (ch0) means ratio 0 (divider output is then ignored).
	logic [lsc_pkg::PROD_W:0]   ratio_sum;
	logic [lsc_pkg::PROD_W-1:0] ratio;
	logic [lsc_pkg::SEG_W-1:0]  seg_w;

	assign ratio_sum = {1'b0, quot_dv} + (lsc_pkg::PROD_W + 1)'(1);
	assign ratio     = (ch0_dv == '0) ? '0 : ratio_sum[lsc_pkg::PROD_W:1];

	// first segment whose limit is not below the ratio; last one otherwise
	always_comb begin
		seg_w = lsc_pkg::SEG_W'(lsc_pkg::SEG_N - 1);
		for (int i = lsc_pkg::SEG_N - 2; i >= 0; i--) begin
			if (ratio <= lsc_pkg::PROD_W'(lsc_pkg::LIM_TAB[chip_scale_package_q][i])) begin
				seg_w = lsc_pkg::SEG_W'(i);
			end
		end
	end

	logic                      valid_s3;
	logic [lsc_pkg::SEG_W-1:0] seg_s3;
	logic [lsc_pkg::CH_W-1:0]  ch0_s3;
	logic [lsc_pkg::CH_W-1:0]  ch1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s3 <= seg_w;
			ch0_s3 <= ch0_dv;
			ch1_s3 <= ch1_dv;
		end
	end

	// ---------------- stage 4: weight both channels ----------------
	// 22 x 10 bits fits 32 bits, so no wrap occurs here.
	logic [lsc_pkg::PROD_W-1:0] t0_w;
	logic [lsc_pkg::PROD_W-1:0] t1_w;

	assign t0_w = lsc_pkg::PROD_W'(ch0_s3)
		* lsc_pkg::PROD_W'(lsc_pkg::OFF_TAB[chip_scale_package_q][seg_s3]);
	assign t1_w = lsc_pkg::PROD_W'(ch1_s3)
		* lsc_pkg::PROD_W'(lsc_pkg::SLOPE_TAB[chip_scale_package_q][seg_s3]);

	logic                       valid_s4;
	logic [lsc_pkg::PROD_W-1:0] t0_s4;
	logic [lsc_pkg::PROD_W-1:0] t1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s4 <= t0_w;
			t1_s4 <= t1_w;
		end
	end

	// ---------------- stage 5: clamp, round, shift ----------------
	logic [lsc_pkg::PROD_W-1:0] diff_w;
	logic [lsc_pkg::PROD_W-1:0] rounded_w;

	assign diff_w    = (t0_s4 > t1_s4) ? (t0_s4 - t1_s4) : '0;
	assign rounded_w = diff_w + lsc_pkg::PROD_W'(1 << (lsc_pkg::LUX_SHIFT - 1));

	logic                      valid_s5;
	logic [lsc_pkg::LUX_W-1:0] lux_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lux_s5 <= rounded_w[lsc_pkg::PROD_W-1:lsc_pkg::LUX_SHIFT];
		end
	end

	// ---------------- output register and skid entry ----------------
	// When the output register is held, a result leaving stage 5 parks in
	// the skid entry; that freezes the pipeline until the output drains.
	logic                      out_valid_q;
	logic [lsc_pkg::LUX_W-1:0] lux_q;
	logic [lsc_pkg::LUX_W-1:0] skid_lux_q;
	logic                      out_take;

	assign out_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q  <= skid_valid_q || valid_s5;
			skid_valid_q <= 1'b0;
		end else if (valid_s5 && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			lux_q <= skid_valid_q ? skid_lux_q : lux_s5;
		end else if (valid_s5 && en) begin
			skid_lux_q <= lux_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign lux       = lux_q;

endmodule

// ===== design/lsc_checker.sv =====
`include "light_sensor_lux_calculator_macros.svh"

module lsc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [lsc_pkg::ADDR_W-1:0]  paddr,
	input logic [lsc_pkg::DATA_W-1:0]  pwdata,
	input logic [lsc_pkg::DATA_W-1:0]  prdata,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lsc_pkg::LUX_W-1:0]   lux
);

	logic integ_rd;
	logic integ_wr;

	assign integ_rd = (paddr[3:2] == lsc_pkg::REG_INTEG_SEL);
	assign integ_wr = psel && penable && pwrite && integ_rd;

	// held result stays put
	`LSC_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(lux))

	// back-pressure only with a result waiting at the output
	`LSC_CHECK_NOW(a_stall_needs_result, in_stall, out_valid)

	// skid fills only behind a stalled output
	`LSC_CHECK_NOW(a_stall_after_out_stall, in_stall, $past(out_stall))

	// integration select reads back what was written
	`LSC_CHECK_NOW(a_integ_readback, integ_wr ##1 integ_rd, prdata[1:0] == $past(pwdata[1:0]))

endmodule

bind light_sensor_lux_calculator lsc_checker u_lsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.lux       (lux)
);

// ===== dv/tb_light_sensor_lux_calculator.sv =====
`timescale 1ns / 1ps

module tb_light_sensor_lux_calculator;

	// run control
	localparam int CYCLE_LIMIT       = 100000;
	localparam int DRAIN_CYCLES      = 40;     // pipeline is ~21 deep plus the skid entry
	localparam int HOLDOFF_CYCLES    = 100;    // long enough to fill the pipe and stall input
	localparam int IDLE_PCT          = 37;
	localparam int ITEMS_PER_SETTING = 89;
	localparam int MAX_REPORTS       = 10;

	// register 3 does not exist; writes there must be dropped
	localparam logic [1:0] REG_SPARE = 2'd3;

	// integration scale factors and fixed-point shifts
	localparam logic [31:0] SHORT_SCALE   = 32'h7517;
	localparam logic [31:0] MEDIUM_SCALE  = 32'h0FE7;
	localparam logic [31:0] NOMINAL_SCALE = 32'd1024;
	localparam int          CH_SH         = 10;
	localparam int          GAIN_SH       = 4;
	localparam int          LUX_SH        = 14;

	// ratio breakpoints, offsets and slopes: [package][segment]
	localparam logic [9:0] RATIO_LIMIT [2][8] = '{
		'{10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A, 10'h29A},
		'{10'h043, 10'h085, 10'h0C8, 10'h10A, 10'h14D, 10'h19A, 10'h29A, 10'h29A}
	};
	localparam logic [9:0] BB_WEIGHT [2][8] = '{
		'{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000},
		'{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
	};
	localparam logic [9:0] IR_WEIGHT [2][8] = '{
		'{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000},
		'{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B, 10'h000}
	};

	// directed requests {broadband, infrared}: count extremes, zero broadband,
	// infrared above broadband, alternating bits, ratios around the breakpoints
	localparam int N_DIRECTED = 19;
	localparam logic [31:0] DIRECTED_PAIRS [N_DIRECTED] = '{
		{16'h0000, 16'h0000}, {16'h0000, 16'hFFFF}, {16'hFFFF, 16'h0000},
		{16'hFFFF, 16'hFFFF}, {16'h0001, 16'h0000}, {16'h0001, 16'h0001},
		{16'hAAAA, 16'h5555}, {16'h5555, 16'hAAAA}, {16'd1000, 16'd3000},
		{16'd1024, 16'd128},  {16'd1024, 16'd130},  {16'd1024, 16'd256},
		{16'd1024, 16'd400},  {16'd1024, 16'd512},  {16'd1024, 16'd640},
		{16'd1024, 16'd820},  {16'd1024, 16'd1333}, {16'd1024, 16'd1340},
		{16'd40000, 16'd50}
	};

	typedef struct packed {
		logic [lsc_pkg::COUNT_W-1:0] bb;
		logic [lsc_pkg::COUNT_W-1:0] ir;
	} counts_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// APB
	logic                       psel    = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite  = 1'b0;
	logic [lsc_pkg::ADDR_W-1:0] paddr   = '0;
	logic [lsc_pkg::DATA_W-1:0] pwdata  = '0;
	logic [lsc_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	// request / result channels
	logic                        in_valid        = 1'b0;
	logic                        in_stall;
	logic [lsc_pkg::COUNT_W-1:0] broadband_count = '0;
	logic [lsc_pkg::COUNT_W-1:0] infrared_count  = '0;
	logic                        out_valid;
	logic                        out_stall       = 1'b0;
	logic [lsc_pkg::LUX_W-1:0]   lux;

	// shadow of the block's registers, starting at their reset values
	logic [1:0] integ_cfg = lsc_pkg::INTEG_LONG;
	logic       unity_cfg = 1'b0;
	logic       pkg_cfg   = 1'b0;

	counts_t                   request_q[$];      // requests not yet offered
	logic [lsc_pkg::LUX_W-1:0] lux_expected_q[$]; // lux of accepted requests, oldest first
	counts_t                   next_req;

	// knobs set by the sequence, read by the driver and the result sink
	int send_idle_pct = IDLE_PCT;
	int recv_idle_pct = IDLE_PCT;
	int holdoff_asked = 0;
	int holdoff_served;
	int holdoff_left;

	int fail_count      = 0;
	int requests_taken  = 0;
	int luxes_checked   = 0;
	int zero_lux_seen   = 0;
	int settings_tried  = 1;
	int cycle_count     = 0;

	light_sensor_lux_calculator DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.broadband_count (broadband_count),
		.infrared_count  (infrared_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.lux             (lux)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Integer lux for one count pair under the shadowed settings. All the
	// intermediate values are 32-bit and wrap, just like the block's math.
	function automatic logic [lsc_pkg::LUX_W-1:0] compute_lux(
			input logic [lsc_pkg::COUNT_W-1:0] bb,
			input logic [lsc_pkg::COUNT_W-1:0] ir);
		logic [31:0] scale, ch0, ch1, quo, ratio, t0, t1, diff;
		int seg;
		case (integ_cfg)
			lsc_pkg::INTEG_SHORT:  scale = SHORT_SCALE;
			lsc_pkg::INTEG_MEDIUM: scale = MEDIUM_SCALE;
			default:               scale = NOMINAL_SCALE; // select 3 behaves as nominal
		endcase
		if (unity_cfg)
			scale = scale << GAIN_SH;
		ch0 = (32'(bb) * scale) >> CH_SH;
		ch1 = (32'(ir) * scale) >> CH_SH;
		// no division when broadband scales to zero
		ratio = 32'd0;
		if (ch0 != 32'd0) begin
			quo   = (ch1 << (CH_SH)) / ch0;
			ratio = (quo + 32'd1) >> 1;
		end
		seg = 7;
		for (int i = 6; i >= 0; i--) begin
			if (ratio <= 32'(RATIO_LIMIT[pkg_cfg][i]))
				seg = i;
		end
		t0 = ch0 * 32'(BB_WEIGHT[pkg_cfg][seg]);
		t1 = ch1 * 32'(IR_WEIGHT[pkg_cfg][seg]);
		// clamp: heavy infrared gives zero rather than a wrapped difference
		diff = (t0 > t1) ? (t0 - t1) : 32'd0;
		diff = diff + (32'd1 << (LUX_SH - 1));
		return diff[31:LUX_SH];
	endfunction

	task automatic flag_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", what);
	endtask

	// One APB write: setup cycle, then access cycle until pready. The shadow
	// follows only the bits the register keeps; unknown indexes are dropped.
	task automatic write_reg(input logic [1:0] idx,
			input logic [lsc_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lsc_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			lsc_pkg::REG_INTEG_SEL:  integ_cfg = value[1:0];
			lsc_pkg::REG_UNITY_GAIN: unity_cfg = value[0];
			lsc_pkg::REG_CHIP_PKG:   pkg_cfg   = value[0];
			default: ;
		endcase
	endtask

	// register value with random junk above the implemented bits half the time
	function automatic logic [lsc_pkg::DATA_W-1:0] with_junk(
			input logic [lsc_pkg::DATA_W-1:0] field,
			input logic [lsc_pkg::DATA_W-1:0] keep);
		return ($urandom_range(1) ? ($urandom() & ~keep) : '0) | field;
	endfunction

	// wait out every request and result, then let the pipeline settle
	task automatic wait_drained();
		do @(negedge clk);
		while (request_q.size() != 0 || in_valid || lux_expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Request driver. Predicts at the accept edge, then offers the next
	// request only once the current one is gone, so a stalled payload holds.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid        <= 1'b0;
			broadband_count <= '0;
			infrared_count  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				lux_expected_q.push_back(compute_lux(broadband_count, infrared_count));
				requests_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = request_q.pop_front();
					in_valid        <= 1'b1;
					broadband_count <= next_req.bb;
					infrared_count  <= next_req.ir;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long result hold-off, counted here so the sink just sees a level.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left   <= 0;
			holdoff_served <= 0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_served != holdoff_asked) begin
			holdoff_left   <= HOLDOFF_CYCLES;
			holdoff_served <= holdoff_asked;
		end
	end

	// Result sink: checks each accepted lux against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lux_expected_q.size() == 0) begin
					flag_failure($sformatf("lux %0d came out with no request pending", lux));
				end else begin
					luxes_checked++;
					if (lux == '0)
						zero_lux_seen++;
					if (lux !== lux_expected_q[0])
						flag_failure($sformatf("lux mismatch on result %0d: expected %0d, got %0d",
							luxes_checked, lux_expected_q[0], lux));
					void'(lux_expected_q.pop_front());
				end
			end
			out_stall <= (holdoff_left != 0) || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results still owed",
				cycle_count, lux_expected_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [lsc_pkg::COUNT_W-1:0] bb, ir;
		logic [31:0]                 scaled_ir;

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// a write to the unused index must leave the reset settings alone
		write_reg(REG_SPARE, with_junk(32'h3, 32'h3));
		@(negedge clk);
		for (int n = 0; n < N_DIRECTED; n++)
			request_q.push_back(counts_t'(DIRECTED_PAIRS[n]));
		wait_drained();

		// walk every register combination: short / medium / nominal / select 3,
		// both gains, both packages; 1x gain at short integration wraps hard
		for (int k = 0; k < 16; k++) begin
			write_reg(lsc_pkg::REG_INTEG_SEL,  with_junk(32'(k[1:0]), 32'h3));
			write_reg(lsc_pkg::REG_UNITY_GAIN, with_junk(32'(k[2]),   32'h1));
			write_reg(lsc_pkg::REG_CHIP_PKG,   with_junk(32'(k[3]),   32'h1));
			settings_tried++;
			@(negedge clk);
			send_idle_pct = (k == 5 || k == 10) ? 0 : IDLE_PCT;
			recv_idle_pct = (k == 5) ? 0 : IDLE_PCT;
			// back-pressure: sink holds off while the driver keeps pushing
			if (k == 10)
				holdoff_asked++;
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				case ($urandom_range(9))
					0, 1, 2: begin
						bb = 16'($urandom());
						ir = 16'($urandom());
					end
					3, 4: begin
						bb = 16'($urandom_range(255));
						ir = 16'($urandom_range(255));
					end
					5, 6, 7: begin
						// aim the ratio across all eight segments
						bb        = 16'($urandom());
						scaled_ir = (32'(bb) * $urandom_range(1400)) >> 10;
						ir        = (scaled_ir > 32'hFFFF) ? 16'hFFFF : scaled_ir[15:0];
					end
					8: begin
						bb = 16'($urandom_range(3));
						ir = 16'($urandom());
					end
					default: begin
						bb = $urandom_range(1) ? 16'hFFFF : 16'h0000;
						ir = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(1));
					end
				endcase
				request_q.push_back(counts_t'{bb, ir});
			end
			wait_drained();
		end

		$display("covered %0d requests over %0d register settings, incl. a %0d-cycle sink hold-off",
			requests_taken, settings_tried, HOLDOFF_CYCLES);
		$display("%0d lux results checked, %0d of them zero, %0d failures",
			luxes_checked, zero_lux_seen, fail_count);
		if (fail_count == 0 && lux_expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/lsc_pkg.sv
design/lsc_div.sv
design/light_sensor_lux_calculator.sv
design/lsc_checker.sv
dv/tb_light_sensor_lux_calculator.sv
